>>> src/wds_pkg.sv
package wds_pkg;

  typedef enum logic [1:0] {
    VERDICT_PASS   = 2'd0,
    VERDICT_NEW    = 2'd1,
    VERDICT_REPEAT = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_WINDOW    = 2'd1,
    CFG_MAX       = 2'd2,
    CFG_BYPASS_PR = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth = 8;

  // transaction from front to back
  typedef struct packed {
    logic        dedup;
    logic [63:0] key;
    logic [31:0] now_ms;
  } wds_cmd_t;

endpackage

>>> src/wds_front.sv
module wds_front
  import wds_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic [63:0]            key_i,
  input  logic [31:0]            now_ms_i,
  input  logic [2:0]             priority_req_i,
  input  logic                   bypass_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output wds_cmd_t               cmd_o,
  output logic                   enable_o,
  output logic [31:0]            window_ms_o,
  output logic [5:0]             max_entries_o
);

  logic       enable_q;
  logic [31:0] window_q;
  logic [5:0] max_q;
  logic [2:0] byp_pr_q;

  // two-entry command queue
  wds_cmd_t   q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;
  wds_cmd_t   cmd_new;

  assign cfg_ready_o = 1'b1;
  assign full_o      = (cnt_q == 2'd2);
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    cmd_new.dedup  = enable_q && !bypass_i && (priority_req_i > byp_pr_q);
    cmd_new.key    = key_i;
    cmd_new.now_ms = now_ms_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      window_q <= 32'd30000;
      max_q    <= 6'd63;
      byp_pr_q <= 3'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgIdxWidth'(CFG_ENABLE):    enable_q <= cfg_data_i[0];
        CfgIdxWidth'(CFG_WINDOW):    window_q <= cfg_data_i;
        CfgIdxWidth'(CFG_MAX):       max_q    <= cfg_data_i[5:0];
        CfgIdxWidth'(CFG_BYPASS_PR): byp_pr_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) q_mem[wr_ptr_q] <= cmd_new;
  end

  assign enable_o      = enable_q;
  assign window_ms_o   = window_q;
  assign max_entries_o = max_q;

  cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !do_pop |=> cnt_q == 2'd2)
    else $error("queue count moved while full");
  pop_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop && !do_push |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("pop not counted");

endmodule

>>> src/wds_back.sv
module wds_back
  import wds_pkg::*;
#(
  parameter int unsigned TableDepth = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  wds_cmd_t    cmd_i,
  input  logic [31:0] window_ms_i,
  input  logic [5:0]  max_entries_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [1:0]  verdict_o,
  output logic [15:0] repeat_count_o,
  output logic [6:0]  occupancy_o
);

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned FW = $clog2(TableDepth + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SCAN, S_EVRD, S_EV, S_SRCH, S_RES
  } state_e;

  // row: key, last seen, repeats
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] seen;
    logic [15:0] reps;
  } row_t;

  row_t mem [TableDepth];
  row_t rd_q;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  row_t          wdata;

  state_e        state_q;
  logic [FW-1:0] fill_q, r_q, w_q, lim_q, excess_q;
  wds_cmd_t      cmd_q;
  logic          hit_q;
  logic [AW-1:0] hit_idx_q;
  logic [15:0]   hit_reps_q;
  logic          out_v_q;
  logic [1:0]    verdict_q;
  logic [15:0]   rep_q;
  logic [FW-1:0] occ_q;
  logic [FW-1:0] lim_c;
  logic [31:0]   idle;
  logic [15:0]   reps_inc;

  assign cmd_ready_o    = (state_q == S_IDLE) && !out_v_q;
  assign empty_o        = !out_v_q;
  assign verdict_o      = verdict_q;
  assign repeat_count_o = rep_q;
  assign occupancy_o    = 7'(occ_q);
  assign idle           = cmd_q.now_ms - rd_q.seen;
  assign reps_inc       = (hit_reps_q == 16'hFFFF) ? hit_reps_q : hit_reps_q + 16'd1;

  always_comb begin
    if (32'(max_entries_i) > TableDepth - 1) lim_c = FW'(TableDepth - 1);
    else lim_c = FW'(max_entries_i);
  end

  always_comb begin
    raddr = r_q[AW-1:0];
    we    = 1'b0;
    waddr = w_q[AW-1:0];
    wdata = rd_q;
    case (state_q)
      S_SCAN: begin
        we = (idle <= window_ms_i);
        raddr = AW'(r_q + FW'(1));
      end
      S_EVRD: raddr = AW'(excess_q);
      S_EV: begin
        we = 1'b1;
        raddr = AW'(w_q + excess_q + FW'(1));
      end
      S_SRCH: raddr = AW'(r_q + FW'(1));
      S_RES: begin
        we = 1'b1;
        if (hit_q) begin
          waddr = hit_idx_q;
          wdata = '{key: cmd_q.key, seen: cmd_q.now_ms, reps: reps_inc};
        end else begin
          waddr = fill_q[AW-1:0];
          wdata = '{key: cmd_q.key, seen: cmd_q.now_ms, reps: 16'd1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_q     <= '0;
      r_q        <= '0;
      w_q        <= '0;
      lim_q      <= '0;
      excess_q   <= '0;
      cmd_q      <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      hit_reps_q <= '0;
      out_v_q    <= 1'b0;
      verdict_q  <= VERDICT_PASS;
      rep_q      <= '0;
      occ_q      <= '0;
    end else begin
      if (out_v_q && pop_i) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            cmd_q <= cmd_i;
            if (!cmd_i.dedup) begin
              out_v_q   <= 1'b1;
              verdict_q <= VERDICT_PASS;
              rep_q     <= '0;
              occ_q     <= fill_q;
            end else begin
              r_q   <= '0;
              w_q   <= '0;
              lim_q <= lim_c;
              state_q <= S_RD;
            end
          end
        end
        S_RD: begin
          if (fill_q == '0) begin
            r_q <= '0;
            hit_q <= 1'b0;
            state_q <= S_RES;
          end else state_q <= S_SCAN;
        end
        S_SCAN: begin
          // compact survivors of the window in place
          if (r_q + FW'(1) == fill_q) begin
            if (((idle <= window_ms_i) ? w_q + FW'(1) : w_q) > lim_q) begin
              excess_q <= ((idle <= window_ms_i) ? w_q + FW'(1) : w_q) - lim_q;
              fill_q   <= lim_q;
              w_q      <= '0;
              state_q  <= (lim_q == '0) ? S_RES : S_EVRD;
            end else begin
              fill_q  <= (idle <= window_ms_i) ? w_q + FW'(1) : w_q;
              r_q     <= '0;
              state_q <= S_EVRD;
              excess_q <= '0;
            end
            hit_q <= 1'b0;
          end else begin
            if (idle <= window_ms_i) w_q <= w_q + FW'(1);
            r_q <= r_q + FW'(1);
          end
        end
        S_EVRD: begin
          if (excess_q == '0) begin
            r_q <= '0;
            state_q <= (fill_q == '0) ? S_RES : S_SRCH;
          end else state_q <= S_EV;
        end
        S_EV: begin
          w_q <= w_q + FW'(1);
          if (w_q + FW'(1) == fill_q) begin
            r_q <= '0;
            // re-read row 0 for the search
            state_q <= S_EVRD;
            excess_q <= '0;
          end
        end
        S_SRCH: begin
          if (rd_q.key == cmd_q.key) begin
            hit_q      <= 1'b1;
            hit_idx_q  <= r_q[AW-1:0];
            hit_reps_q <= rd_q.reps;
            state_q    <= S_RES;
          end else if (r_q + FW'(1) == fill_q) begin
            hit_q   <= 1'b0;
            state_q <= S_RES;
          end else r_q <= r_q + FW'(1);
        end
        S_RES: begin
          out_v_q <= 1'b1;
          if (hit_q) begin
            verdict_q <= VERDICT_REPEAT;
            rep_q     <= reps_inc;
            occ_q     <= fill_q;
          end else begin
            verdict_q <= VERDICT_NEW;
            rep_q     <= 16'd1;
            occ_q     <= fill_q + FW'(1);
            fill_q    <= fill_q + FW'(1);
          end
          hit_q   <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= TableDepth)
    else $error("fill above depth");
  res_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RES |=> out_v_q)
    else $error("result not presented");
  no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !cmd_ready_o)
    else $error("command taken while busy");

endmodule

>>> src/windowed_duplicate_suppressor.sv
// Suppresses repeated event keys inside an idle window. Each non-passing
// event walks the table serially: a compaction pass over the current fill
// (one entry per cycle), an eviction copy of at most the kept entries, then a
// linear search and one write-back, through a table memory with one read and
// one write port. Bypassed, low-priority or disabled events skip the table
// walk. A two-entry queue decouples the input from the table walk, and one
// result register holds the answer until popped; the walk takes no further
// event while that register is occupied.
module windowed_duplicate_suppressor
  import wds_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  input  logic                   push,
  output logic                   full,
  input  logic [63:0]            key_i,
  input  logic [31:0]            now_ms_i,
  input  logic [2:0]             priority_req_i,
  input  logic                   bypass_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             verdict_o,
  output logic [15:0]            repeat_count_o,
  output logic [6:0]             occupancy_o
);

  logic        cmd_valid, cmd_ready, enable;
  wds_cmd_t    cmd;
  logic [31:0] window_ms;
  logic [5:0]  max_entries;

  wds_front u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .push_i(push), .full_o(full), .key_i, .now_ms_i, .priority_req_i, .bypass_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd),
    .enable_o(enable), .window_ms_o(window_ms), .max_entries_o(max_entries)
  );

  wds_back #(.TableDepth(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .window_ms_i(window_ms), .max_entries_i(max_entries),
    .empty_o(empty), .pop_i(pop), .verdict_o, .repeat_count_o, .occupancy_o
  );

  cfg_always: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port stalled");
  en_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !enable && cmd_valid && cmd_ready |-> !cmd.dedup)
    else $error("dedup while disabled");
  pass_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && verdict_o == VERDICT_PASS |-> repeat_count_o == 16'd0)
    else $error("pass with count");

endmodule

>>> dv/windowed_duplicate_suppressor_tb.sv
module windowed_duplicate_suppressor_tb
  import wds_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 64;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 300;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] now_ms;
    logic [2:0]  prio;
    logic        bypass;
  } event_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] repeats;
    logic [6:0]  occupancy;
  } answer_t;

  // directed row: event plus a typed-in answer where it is obvious
  typedef struct packed {
    event_t  ev;
    logic    known;
    answer_t ans;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic [63:0] key_i = '0;
  logic [31:0] now_ms_i = '0;
  logic [2:0] priority_req_i = '0;
  logic bypass_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] verdict_o;
  logic [15:0] repeat_count_o;
  logic [6:0] occupancy_o;

  always #1 clk_i = ~clk_i;

  windowed_duplicate_suppressor i_dut (.*);

  // predictor state
  logic [63:0] tbl_key [Depth];
  logic [31:0] tbl_seen [Depth];
  logic [15:0] tbl_rep [Depth];
  int unsigned tbl_fill;
  logic        cur_enable;
  logic [31:0] cur_window;
  logic [5:0]  cur_max;
  logic [2:0]  cur_bypass_pr;

  answer_t     expected_answers[$];
  logic        typed_answer[$];
  answer_t     typed_value[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          hold_off = 1'b0;
  bit          timed_out = 1'b0;

  function automatic answer_t predict_verdict(event_t ev);
    answer_t a;
    int unsigned w, limit, excess;
    if (!cur_enable || ev.bypass || ev.prio <= cur_bypass_pr) begin
      a.verdict = VERDICT_PASS;
      a.repeats = '0;
      a.occupancy = 7'(tbl_fill);
      return a;
    end
    w = 0;
    for (int unsigned r = 0; r < tbl_fill; r++) begin
      if (32'(ev.now_ms - tbl_seen[r]) <= cur_window) begin
        tbl_key[w] = tbl_key[r];
        tbl_seen[w] = tbl_seen[r];
        tbl_rep[w] = tbl_rep[r];
        w++;
      end
    end
    tbl_fill = w;
    limit = (cur_max > Depth - 1) ? Depth - 1 : cur_max;
    if (tbl_fill > limit) begin
      excess = tbl_fill - limit;
      for (int unsigned i = 0; i < limit; i++) begin
        tbl_key[i] = tbl_key[i + excess];
        tbl_seen[i] = tbl_seen[i + excess];
        tbl_rep[i] = tbl_rep[i + excess];
      end
      tbl_fill = limit;
    end
    for (int unsigned i = 0; i < tbl_fill; i++) begin
      if (tbl_key[i] == ev.key) begin
        tbl_seen[i] = ev.now_ms;
        if (tbl_rep[i] != 16'hffff) tbl_rep[i] = tbl_rep[i] + 16'd1;
        a.verdict = VERDICT_REPEAT;
        a.repeats = tbl_rep[i];
        a.occupancy = 7'(tbl_fill);
        return a;
      end
    end
    if (tbl_fill < Depth) begin
      tbl_key[tbl_fill] = ev.key;
      tbl_seen[tbl_fill] = ev.now_ms;
      tbl_rep[tbl_fill] = 16'd1;
      tbl_fill++;
    end
    a.verdict = VERDICT_NEW;
    a.repeats = 16'd1;
    a.occupancy = 7'(tbl_fill);
    return a;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgIdxWidth'(idx);
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ENABLE:    cur_enable = data[0];
      CFG_WINDOW:    cur_window = data;
      CFG_MAX:       cur_max = data[5:0];
      CFG_BYPASS_PR: cur_bypass_pr = data[2:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // drives one event; holds push until the queue is not full, with no lowering in between
  task automatic send_event(event_t ev, logic known, answer_t ans);
    answer_t a;
    push <= 1'b1;
    key_i <= ev.key;
    now_ms_i <= ev.now_ms;
    priority_req_i <= ev.prio;
    bypass_i <= ev.bypass;
    do @(posedge clk_i); while (full);
    a = predict_verdict(ev);
    expected_answers = {expected_answers, a};
    typed_answer = {typed_answer, known};
    typed_value = {typed_value, ans};
  endtask

  task automatic gap(int unsigned n);
    if (n == 0) return;
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic event_t rand_event(int unsigned nkeys, logic [31:0] t);
    event_t ev;
    ev.key = (nkeys == 0) ? {$urandom, $urandom} : 64'($urandom_range(nkeys - 1)) ^
             64'hA5A5_0000_0000_5A5A;
    ev.now_ms = t;
    ev.prio = 3'($urandom_range(7));
    ev.bypass = ($urandom_range(15) == 0);
    return ev;
  endfunction

  task automatic random_phase(int unsigned count, int unsigned nkeys, int unsigned step_max);
    logic [31:0] t;
    int unsigned burst;
    t = $urandom;
    burst = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(12, 1);
        gap(($urandom_range(3) == 0) ? 0 : $urandom_range(40));
      end
      burst--;
      t = t + $urandom_range(step_max);
      send_event(rand_event(nkeys, t), 1'b0, '0);
    end
    push <= 1'b0;
  endtask

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int unsigned k;
    k = 0;
    forever begin
      @(posedge clk_i);
      k++;
      pop <= !hold_off && ((k % 7) < 4 || (k % 97) > 60);
    end
  end

  always @(posedge clk_i) begin
    answer_t exp_a, exp_t;
    logic    has_typed;
    if (rst_ni && pop && !empty) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result verdict=%0d count=%0d occ=%0d", $time,
                 verdict_o, repeat_count_o, occupancy_o);
        errors++;
      end else begin
        exp_a = expected_answers.pop_front();
        has_typed = typed_answer.pop_front();
        exp_t = typed_value.pop_front();
        if (has_typed) exp_a = exp_t;
        if (verdict_o != exp_a.verdict) begin
          $display("%0t: verdict expected %0d actual %0d", $time, exp_a.verdict, verdict_o);
          errors++;
        end
        if (repeat_count_o != exp_a.repeats) begin
          $display("%0t: repeat_count expected %0d actual %0d", $time, exp_a.repeats,
                   repeat_count_o);
          errors++;
        end
        if (occupancy_o != exp_a.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, exp_a.occupancy,
                   occupancy_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic row_t mk(logic [63:0] key, logic [31:0] t, logic [2:0] p, logic b,
                               logic known, verdict_e v, logic [15:0] c, logic [6:0] o);
    row_t r;
    r.ev = '{key, t, p, b};
    r.known = known;
    r.ans = '{v, c, o};
    return r;
  endfunction

  initial begin
    row_t directed[$];
    cur_enable = 1'b1;
    cur_window = 32'd30000;
    cur_max = 6'd63;
    cur_bypass_pr = 3'd1;
    tbl_fill = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset-time behaviour and field extremes
    directed = {directed, mk(64'h0, 32'h0, 3'd7, 1'b0, 1'b1, VERDICT_NEW, 16'd1, 7'd1)};
    directed = {directed, mk(64'h0, 32'h10, 3'd7, 1'b0, 1'b1, VERDICT_REPEAT, 16'd2, 7'd1)};
    directed = {directed, mk('1, 32'h20, 3'd2, 1'b0, 1'b1, VERDICT_NEW, 16'd1, 7'd2)};
    directed = {directed, mk('1, 32'h30, 3'd0, 1'b0, 1'b1, VERDICT_PASS, 16'd0, 7'd2)};
    directed = {directed, mk('1, 32'h40, 3'd1, 1'b0, 1'b1, VERDICT_PASS, 16'd0, 7'd2)};
    directed = {directed, mk('1, 32'h50, 3'd7, 1'b1, 1'b1, VERDICT_PASS, 16'd0, 7'd2)};
    // exactly at window, then beyond it, then wrapped time
    directed = {directed, mk('1, 32'd30016, 3'd5, 1'b0, 1'b0, VERDICT_PASS, '0, '0)};
    directed = {directed, mk(64'h0, 32'd60021, 3'd5, 1'b0, 1'b0, VERDICT_PASS, '0, '0)};
    directed = {directed, mk(64'h8000_0000_0000_0001, 32'hffff_fff0, 3'd4, 1'b0, 1'b0,
                             VERDICT_PASS, '0, '0)};
    directed = {directed, mk(64'h8000_0000_0000_0001, 32'h0000_0100, 3'd4, 1'b0, 1'b0,
                             VERDICT_PASS, '0, '0)};
    foreach (directed[i]) send_event(directed[i].ev, directed[i].known, directed[i].ans);
    push <= 1'b0;
    wait_drained();

    // tiny table with zero window: entries live only at the same millisecond
    write_reg(CFG_WINDOW, 32'd0);
    write_reg(CFG_MAX, 32'd1);
    write_reg(CFG_BYPASS_PR, 32'd0);
    for (int unsigned i = 0; i < 6; i++)
      send_event('{64'(i % 2), 32'd1000 + 32'(i / 3), 3'd1, 1'b0}, 1'b0, '0);
    push <= 1'b0;
    wait_drained();

    // limit zero empties the table before the lookup
    write_reg(CFG_MAX, 32'd0);
    write_reg(CFG_WINDOW, 32'hffff_ffff);
    for (int unsigned i = 0; i < 4; i++)
      send_event('{64'h77, 32'd5, 3'd3, 1'b0}, 1'b0, '0);
    push <= 1'b0;
    wait_drained();

    // dedup off
    write_reg(CFG_ENABLE, 32'd0);
    send_event('{64'h77, 32'd6, 3'd7, 1'b0}, 1'b1, '{VERDICT_PASS, 16'd0, 7'(tbl_fill)});
    push <= 1'b0;
    wait_drained();
    write_reg(CFG_ENABLE, 32'd1);
    write_reg(CFG_MAX, 32'd63);

    // long receiver hold-off while the sender keeps pushing
    write_reg(CFG_BYPASS_PR, 32'd7);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(20, 8, 100);
    join
    wait_drained();

    // random phases over several settings
    write_reg(CFG_BYPASS_PR, 32'd2);
    write_reg(CFG_WINDOW, 32'd500);
    random_phase(150, 12, 120);
    wait_drained();
    write_reg(CFG_MAX, 32'd5);
    write_reg(CFG_WINDOW, 32'd30000);
    random_phase(120, 10, 50);
    wait_drained();
    write_reg(CFG_MAX, 32'd63);
    write_reg(CFG_WINDOW, 32'hffff_ffff);
    write_reg(CFG_BYPASS_PR, 32'd0);
    random_phase(150, 80, 1000);
    wait_drained();
    write_reg(CFG_WINDOW, 32'd200);
    write_reg(CFG_BYPASS_PR, 32'd1);
    random_phase(130, 0, 100);
    wait_drained();
    // few keys at short steps, so entries collect many repeats
    write_reg(CFG_WINDOW, 32'd1000);
    random_phase(40, 3, 10);
    wait_drained();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
